FILE: hdl/tsr_pkg.sv
// ---------------------------------------------------------------------------
// tsr_pkg
// Shared types and codes of the typed stack with register table: the
// request and response beats, the stored entry and the operation codes.
// ---------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

   // Operation codes carried in the func field.
   localparam logic [3:0] FN_PUSH     = 4'd0;
   localparam logic [3:0] FN_POP      = 4'd1;
   localparam logic [3:0] FN_PEEK     = 4'd2;
   localparam logic [3:0] FN_DUP      = 4'd3;
   localparam logic [3:0] FN_SWAP     = 4'd4;
   localparam logic [3:0] FN_REGGET   = 4'd5;
   localparam logic [3:0] FN_REGSET   = 4'd6;
   localparam logic [3:0] FN_MARK     = 4'd7;
   localparam logic [3:0] FN_CLEAR    = 4'd8;
   localparam logic [3:0] FN_NEXTFREE = 4'd9;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BADIDX   = 3'd3;
   localparam logic [2:0] ST_MISMATCH = 3'd4;
   localparam logic [2:0] ST_FEW      = 3'd5;

   localparam logic [4:0] MASK_ANY = 5'd31;

   typedef struct packed {
      logic [2:0]  tag;
      logic [31:0] value;
      logic [31:0] handle;
   } stack_entry_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [2:0]  entry_type;
      logic [31:0] entry_value;
      logic [31:0] entry_handle;
      logic [4:0]  expect_mask;
      logic [7:0]  reg_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  out_type;
      logic [31:0] out_value;
      logic [31:0] out_handle;
      logic [7:0]  found_index;
      logic [5:0]  depth;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/typed_stack_with_register_table.sv
// ---------------------------------------------------------------------------
// typed_stack_with_register_table
// Bounded stack of tagged entries beside a table of marked registers.
//
// A request beat on req_ carries one operation (push, pop, peek, dup, swap,
// register get and set, mark, clear, next-free search); each one yields
// exactly one response beat on rsp_ with a status code and the stack depth.
// The stack and the register table sit in synchronous memories that are
// read in the cycle a request is accepted; the S_EXEC state then modifies,
// writes back and loads the response register. Most operations finish in
// S_EXEC; swap adds an S_SWAP2 step because its two writes share the single
// write port, and the next-free search stays in S_EXEC, walking the mark
// bits one register per cycle until it finds a free one or has seen all.
// The response register lets the next request be accepted while a response
// still waits; if rsp_ready stays low, the following operation holds in its
// last step and commits that step only once the response register frees.
// Reset empties the stack and clears all registers and mark bits; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module typed_stack_with_register_table import tsr_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int REG_COUNT   = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam logic [CW-1:0]  FULL_COUNT = CW'(STACK_DEPTH);
   localparam logic [8:0]     REG_LIMIT  = 9'(REG_COUNT);
   localparam logic [RAW-1:0] LAST_REG   = RAW'(REG_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SWAP2
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    top_ff, top_in;
   req_type          op_ff, op_in;
   logic [RAW-1:0]   scan_pos_ff, scan_pos_in;
   logic [RAW-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [REG_COUNT-1:0] mark_ff, mark_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             slot_free;
   logic             finish;
   rsp_type          res;
   logic             req_idx_ok;
   logic             op_idx_ok;
   logic [CW-1:0]    top_m1;
   logic [CW-1:0]    top_m2;
   logic [SAW-1:0]   addr_a;
   logic [SAW-1:0]   addr_b;
   logic [SAW-1:0]   addr_top;
   logic [RAW-1:0]   op_reg;
   logic             tag_ok;
   logic [7:0]       mask_ext;

   stack_entry_type  stk_a;
   stack_entry_type  stk_b;
   stack_entry_type  reg_rd;
   logic             stk_wr_en;
   logic [SAW-1:0]   stk_wr_addr;
   stack_entry_type  stk_wr_data;
   logic             reg_wr_en;
   stack_entry_type  push_entry;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_idx_ok = {1'b0, req_data.reg_index} < REG_LIMIT;
   assign op_idx_ok  = {1'b0, op_ff.reg_index} < REG_LIMIT;
   assign op_reg     = op_ff.reg_index[RAW-1:0];

   // The top stays put from accept until write-back, so these addresses
   // serve both the reads at accept and the writes afterward.
   assign top_m1   = top_ff - CW'(1);
   assign top_m2   = top_ff - CW'(2);
   assign addr_a   = top_m1[SAW-1:0];
   assign addr_b   = top_m2[SAW-1:0];
   assign addr_top = top_ff[SAW-1:0];

   assign mask_ext = {3'b000, op_ff.expect_mask};
   assign tag_ok   = (op_ff.expect_mask == MASK_ANY) || mask_ext[stk_a.tag];

   assign push_entry.tag    = op_ff.entry_type;
   assign push_entry.value  = op_ff.entry_value;
   assign push_entry.handle = op_ff.entry_handle;

   tsr_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .AW    (SAW)
   ) u_stack (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (stk_a),
      .rd_data_b (stk_b),
      .wr_en     (stk_wr_en),
      .wr_addr   (stk_wr_addr),
      .wr_data   (stk_wr_data)
   );

   tsr_reg_file #(
      .COUNT (REG_COUNT),
      .AW    (RAW)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_idx_ok),
      .rd_addr (req_data.reg_index[RAW-1:0]),
      .rd_data (reg_rd),
      .wr_en   (reg_wr_en),
      .wr_addr (op_reg),
      .wr_data (stk_a)
   );

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      op_in        = op_ff;
      scan_pos_in  = scan_pos_ff;
      scan_cnt_in  = scan_cnt_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = addr_top;
      stk_wr_data  = push_entry;
      reg_wr_en    = 1'b0;
      res          = '0;
      finish       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_data;
               scan_pos_in = req_idx_ok ? req_data.reg_index[RAW-1:0] : '0;
               scan_cnt_in = '0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            finish = 1'b1;
            case (op_ff.func) inside
               FN_PUSH: begin
                  if (top_ff == FULL_COUNT) begin
                     res.status = ST_FULL;
                  end else begin
                     stk_wr_en = 1'b1;
                     top_in    = top_ff + CW'(1);
                  end
               end
               FN_POP, FN_PEEK: begin
                  if (top_ff == '0) begin
                     res.status = ST_EMPTY;
                  end else begin
                     res.out_type   = stk_a.tag;
                     res.out_value  = stk_a.value;
                     res.out_handle = stk_a.handle;
                     if (!tag_ok) begin
                        res.status = ST_MISMATCH;
                     end
                     if (op_ff.func == FN_POP) begin
                        top_in = top_m1;
                     end
                  end
               end
               FN_DUP: begin
                  if (top_ff == '0) begin
                     res.status = ST_EMPTY;
                  end else if (top_ff == FULL_COUNT) begin
                     res.status = ST_FULL;
                  end else begin
                     stk_wr_en   = 1'b1;
                     stk_wr_data = stk_a;
                     top_in      = top_ff + CW'(1);
                  end
               end
               FN_SWAP: begin
                  if (top_ff < CW'(2)) begin
                     res.status = ST_FEW;
                  end else begin
                     // First half: the entry below moves to the top slot.
                     finish      = 1'b0;
                     stk_wr_en   = 1'b1;
                     stk_wr_addr = addr_a;
                     stk_wr_data = stk_b;
                     state_in    = S_SWAP2;
                  end
               end
               FN_REGGET: begin
                  if (!op_idx_ok) begin
                     res.status = ST_BADIDX;
                  end else if (top_ff == FULL_COUNT) begin
                     res.status = ST_FULL;
                  end else begin
                     stk_wr_en      = 1'b1;
                     stk_wr_data    = reg_rd;
                     top_in         = top_ff + CW'(1);
                     res.out_type   = reg_rd.tag;
                     res.out_value  = reg_rd.value;
                     res.out_handle = reg_rd.handle;
                  end
               end
               FN_REGSET: begin
                  if (!op_idx_ok) begin
                     res.status = ST_BADIDX;
                  end else if (top_ff == '0) begin
                     res.status = ST_EMPTY;
                  end else begin
                     reg_wr_en      = 1'b1;
                     top_in         = top_m1;
                     res.out_type   = stk_a.tag;
                     res.out_value  = stk_a.value;
                     res.out_handle = stk_a.handle;
                  end
               end
               FN_MARK, FN_CLEAR: begin
                  if (!op_idx_ok) begin
                     res.status = ST_BADIDX;
                  end else begin
                     mark_in[op_reg] = (op_ff.func == FN_MARK);
                  end
               end
               FN_NEXTFREE: begin
                  if (!mark_ff[scan_pos_ff]) begin
                     res.found_index = 8'(scan_pos_ff);
                  end else if (scan_cnt_ff == LAST_REG) begin
                     res.status = ST_FULL;
                  end else begin
                     finish      = 1'b0;
                     scan_cnt_in = scan_cnt_ff + RAW'(1);
                     scan_pos_in = (scan_pos_ff == LAST_REG) ? '0
                                                            : scan_pos_ff + RAW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         S_SWAP2: begin
            finish      = 1'b1;
            stk_wr_en   = 1'b1;
            stk_wr_addr = addr_b;
            stk_wr_data = stk_a;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finishing beat commits only when the response register can take
      // its result; otherwise it repeats next cycle from unchanged inputs.
      if (finish) begin
         if (slot_free) begin
            res.depth    = 6'(top_in);
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            stk_wr_en = 1'b0;
            reg_wr_en = 1'b0;
            top_in    = top_ff;
            mark_in   = mark_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      scan_pos_ff <= scan_pos_in;
      scan_cnt_ff <= scan_cnt_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/tsr_stack_ram.sv
// ---------------------------------------------------------------------------
// tsr_stack_ram
// Stack storage: one write port and two registered read ports, so the top
// entry and the one below it can be fetched together.
// ---------------------------------------------------------------------------
`default_nettype none

module tsr_stack_ram import tsr_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output stack_entry_type    rd_data_a,
   output stack_entry_type    rd_data_b,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  stack_entry_type    wr_data
);

   stack_entry_type mem [DEPTH];
   stack_entry_type rd_a_ff;
   stack_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: hdl/tsr_reg_file.sv
// ---------------------------------------------------------------------------
// tsr_reg_file
// Register table storage with a registered read port. A valid bit per
// register makes an entry that was never written read as all zero.
// ---------------------------------------------------------------------------
`default_nettype none

module tsr_reg_file import tsr_pkg::*; #(
   parameter int COUNT = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output stack_entry_type    rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  stack_entry_type    wr_data
);

   stack_entry_type  mem [COUNT];
   logic [COUNT-1:0] valid_ff;
   stack_entry_type  rd_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

`default_nettype wire

FILE: sim/tb_typed_stack_with_register_table.sv
// ---------------------------------------------------------------------------
// tb_typed_stack_with_register_table
// Self-checking bench for the typed stack with register table.
//
// A short table of directed requests covers the empty, bad-index,
// type-mismatch and too-few-entries cases first. Random requests follow, in
// phases that favor growing, shrinking, marking, unmarking or none. Every
// accepted request runs through a behavioral copy of the stack and register
// table, and every response beat is compared with the oldest expectation.
// The sender works in bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------

module tb_typed_stack_with_register_table;
   timeunit 1ns;
   timeprecision 1ps;

   import tsr_pkg::*;

   localparam int STACK_DEPTH = 32;
   localparam int REG_COUNT   = 16;
   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 40;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MARK, MIX_UNMARK, MIX_ANY} mix_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Side band that travels with each request beat: a typed-in expectation.
   bit      req_typed;
   rsp_type req_typed_rsp;

   // Behavioral copy of the block state.
   stack_entry_type stk[STACK_DEPTH];
   int unsigned     stk_count;
   stack_entry_type regs[REG_COUNT];
   bit              reg_marked[REG_COUNT];

   rsp_type      rsp_due[$];
   plan_row_type plan[$];
   int           mismatch_count;
   int           quiet_cycles;

   int   stall_left;
   int   ready_phase;
   int   ready_mode;

   typed_stack_with_register_table #(
      .STACK_DEPTH (STACK_DEPTH),
      .REG_COUNT   (REG_COUNT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit tag_fits(logic [2:0] tag, logic [4:0] mask);
      if (mask == MASK_ANY) return 1'b1;
      if (tag >= 3'd5) return 1'b0;
      return mask[tag];
   endfunction

   // Applies one request to the behavioral state and returns its response.
   function automatic rsp_type stack_op(req_type r);
      rsp_type         o;
      int unsigned     idx;
      int unsigned     pos;
      stack_entry_type held;
      bit              found;
      o = '0;
      o.status = ST_OK;
      idx = r.reg_index;
      case (r.func)
         FN_PUSH: begin
            if (stk_count >= STACK_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               stk[stk_count] = '{tag: r.entry_type, value: r.entry_value,
                                  handle: r.entry_handle};
               stk_count++;
            end
         end
         FN_POP, FN_PEEK: begin
            if (stk_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               held = stk[stk_count - 1];
               o.out_type = held.tag;
               o.out_value = held.value;
               o.out_handle = held.handle;
               if (!tag_fits(held.tag, r.expect_mask)) o.status = ST_MISMATCH;
               if (r.func == FN_POP) stk_count--;
            end
         end
         FN_DUP: begin
            if (stk_count == 0) begin
               o.status = ST_EMPTY;
            end else if (stk_count >= STACK_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               stk[stk_count] = stk[stk_count - 1];
               stk_count++;
            end
         end
         FN_SWAP: begin
            if (stk_count < 2) begin
               o.status = ST_FEW;
            end else begin
               held = stk[stk_count - 1];
               stk[stk_count - 1] = stk[stk_count - 2];
               stk[stk_count - 2] = held;
            end
         end
         FN_REGGET: begin
            if (idx >= REG_COUNT) begin
               o.status = ST_BADIDX;
            end else if (stk_count >= STACK_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               stk[stk_count] = regs[idx];
               stk_count++;
               o.out_type = regs[idx].tag;
               o.out_value = regs[idx].value;
               o.out_handle = regs[idx].handle;
            end
         end
         FN_REGSET: begin
            if (idx >= REG_COUNT) begin
               o.status = ST_BADIDX;
            end else if (stk_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               regs[idx] = stk[stk_count - 1];
               stk_count--;
               o.out_type = regs[idx].tag;
               o.out_value = regs[idx].value;
               o.out_handle = regs[idx].handle;
            end
         end
         FN_MARK, FN_CLEAR: begin
            if (idx >= REG_COUNT) o.status = ST_BADIDX;
            else reg_marked[idx] = (r.func == FN_MARK);
         end
         FN_NEXTFREE: begin
            pos = (idx >= REG_COUNT) ? 0 : idx;
            found = 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
               if (!found) begin
                  if (!reg_marked[pos]) begin
                     found = 1'b1;
                     o.found_index = pos[7:0];
                  end else begin
                     pos = (pos + 1) % REG_COUNT;
                  end
               end
            end
            if (!found) o.status = ST_FULL;
         end
         default: ;
      endcase
      o.depth = stk_count[5:0];
      return o;
   endfunction

   function automatic req_type rq(logic [3:0] fn, logic [2:0] tag, logic [31:0] val,
                                  logic [31:0] hdl, logic [4:0] mask, logic [7:0] idx);
      req_type r;
      r.func = fn;
      r.entry_type = tag;
      r.entry_value = val;
      r.entry_handle = hdl;
      r.expect_mask = mask;
      r.reg_index = idx;
      return r;
   endfunction

   function automatic rsp_type rs(logic [2:0] st, logic [2:0] ty, logic [31:0] val,
                                  logic [31:0] hdl, logic [7:0] found, logic [5:0] dep);
      rsp_type o;
      o.status = st;
      o.out_type = ty;
      o.out_value = val;
      o.out_handle = hdl;
      o.found_index = found;
      o.depth = dep;
      return o;
   endfunction

   function automatic req_type rand_req(mix_type mix);
      int unsigned w;
      logic [3:0]  fn;
      logic [2:0]  tag;
      logic [4:0]  mask;
      logic [7:0]  idx;
      w = $urandom_range(0, 99);
      fn = 4'($urandom_range(0, 9));
      if (w < 3) begin
         fn = 4'($urandom_range(10, 15));
      end else begin
         case (mix)
            MIX_GROW: begin
               if (w < 60) fn = FN_PUSH;
               else if (w < 70) fn = FN_DUP;
               else if (w < 80) fn = FN_REGGET;
            end
            MIX_SHRINK: begin
               if (w < 40) fn = FN_POP;
               else if (w < 55) fn = FN_REGSET;
               else if (w < 65) fn = FN_PEEK;
               else if (w < 75) fn = FN_SWAP;
            end
            MIX_MARK: begin
               if (w < 50) fn = FN_MARK;
               else if (w < 75) fn = FN_NEXTFREE;
            end
            MIX_UNMARK: begin
               if (w < 40) fn = FN_CLEAR;
               else if (w < 65) fn = FN_NEXTFREE;
            end
            default: ;
         endcase
      end
      tag = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
      mask = ($urandom_range(0, 9) < 3) ? MASK_ANY : 5'($urandom_range(0, 31));
      idx = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, REG_COUNT - 1));
      return rq(fn, tag, $urandom, $urandom, mask, idx);
   endfunction

   // Drives one request beat and holds it until it is accepted.
   task automatic send_beat(req_type r, bit typed, rsp_type exp);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      req_typed <= typed;
      req_typed_rsp <= exp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender pacing: random bursts, then random gaps; some stretches never pause.
   int burst_left;

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Receiver stall pattern, re-chosen whenever its phase counter runs out.
   always @(negedge clock) begin
      if (ready_phase == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_phase <= $urandom_range(50, 300);
      end else begin
         ready_phase <= ready_phase - 1;
      end
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            default: begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
            end
         endcase
      end
   end

   // Monitor: predicts on each request beat, checks each response beat.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type pred;
      bit      bad;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_valid && req_ready) begin
            pred = stack_op(req_data);
            rsp_due.push_back(req_typed ? req_typed_rsp : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response beat: status %0d depth %0d",
                           rsp_data.status, rsp_data.depth);
            end else begin
               want = rsp_due.pop_front();
               bad = (rsp_data.status !== want.status) ||
                     (rsp_data.out_type !== want.out_type) ||
                     (rsp_data.out_value !== want.out_value) ||
                     (rsp_data.out_handle !== want.out_handle) ||
                     (rsp_data.found_index !== want.found_index) ||
                     (rsp_data.depth !== want.depth);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("response mismatch at %0t", $realtime);
                     $display("  expected st %0d ty %0d val %h hdl %h found %0d depth %0d",
                              want.status, want.out_type, want.out_value,
                              want.out_handle, want.found_index, want.depth);
                     $display("  actual   st %0d ty %0d val %h hdl %h found %0d depth %0d",
                              rsp_data.status, rsp_data.out_type, rsp_data.out_value,
                              rsp_data.out_handle, rsp_data.found_index, rsp_data.depth);
                  end
               end
            end
         end
      end
   end

   initial begin
      wait (quiet_cycles >= IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      mix_type mix;
      int      mix_left;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      req_typed = 1'b0;
      req_typed_rsp = '0;
      rsp_ready = 1'b0;
      stall_left = 0;
      ready_phase = 0;
      ready_mode = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      burst_left = 0;
      stk_count = 0;
      for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
      for (int i = 0; i < REG_COUNT; i++) begin
         regs[i] = '0;
         reg_marked[i] = 1'b0;
      end

      // Directed rows; typed-in responses are those that follow from reset
      // and from the simple error cases.
      plan.push_back('{rq(FN_POP, 0, 0, 0, MASK_ANY, 0), 1, rs(ST_EMPTY, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_PEEK, 0, 0, 0, MASK_ANY, 0), 1, rs(ST_EMPTY, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_DUP, 0, 0, 0, 0, 0), 1, rs(ST_EMPTY, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_SWAP, 0, 0, 0, 0, 0), 1, rs(ST_FEW, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_REGSET, 0, 0, 0, 0, 3), 1, rs(ST_EMPTY, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_REGSET, 0, 0, 0, 0, 255), 1, rs(ST_BADIDX, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_REGGET, 0, 0, 0, 0, 16), 1, rs(ST_BADIDX, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_MARK, 0, 0, 0, 0, 16), 1, rs(ST_BADIDX, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_CLEAR, 0, 0, 0, 0, 255), 1, rs(ST_BADIDX, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_NEXTFREE, 0, 0, 0, 0, 200), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(4'hF, 3'h7, '1, '1, 5'h1F, 8'hFF), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      plan.push_back('{rq(FN_PUSH, 3'd7, 32'hFFFF_FFFF, 0, 0, 0), 1,
                       rs(ST_OK, 0, 0, 0, 0, 1)});
      plan.push_back('{rq(FN_SWAP, 0, 0, 0, 0, 0), 1, rs(ST_FEW, 0, 0, 0, 0, 1)});
      plan.push_back('{rq(FN_PEEK, 0, 0, 0, MASK_ANY, 0), 1,
                       rs(ST_OK, 3'd7, 32'hFFFF_FFFF, 0, 0, 1)});
      plan.push_back('{rq(FN_PEEK, 0, 0, 0, 5'h1E, 0), 1,
                       rs(ST_MISMATCH, 3'd7, 32'hFFFF_FFFF, 0, 0, 1)});
      plan.push_back('{rq(FN_PUSH, 3'd4, 0, 32'hFFFF_FFFF, 0, 0), 1,
                       rs(ST_OK, 0, 0, 0, 0, 2)});
      plan.push_back('{rq(FN_SWAP, 0, 0, 0, 0, 0), 0, '0});
      plan.push_back('{rq(FN_POP, 0, 0, 0, 5'h10, 0), 0, '0});
      plan.push_back('{rq(FN_PEEK, 0, 0, 0, 5'h10, 0), 0, '0});
      plan.push_back('{rq(FN_REGGET, 0, 0, 0, 0, 15), 0, '0});
      plan.push_back('{rq(FN_REGSET, 0, 0, 0, 0, 0), 0, '0});
      plan.push_back('{rq(FN_MARK, 0, 0, 0, 0, 0), 0, '0});
      plan.push_back('{rq(FN_NEXTFREE, 0, 0, 0, 0, 0), 0, '0});
      plan.push_back('{rq(FN_DUP, 0, 0, 0, 0, 0), 0, '0});
      plan.push_back('{rq(FN_REGGET, 0, 0, 0, 0, 0), 0, '0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_beat(plan[i].req, plan[i].typed, plan[i].rsp);
         pace_sender();
      end

      mix = MIX_ANY;
      mix_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (mix_left == 0) begin
            mix = mix_type'($urandom_range(0, 4));
            mix_left = $urandom_range(60, 150);
         end
         mix_left--;
         send_beat(rand_req(mix), 1'b0, '0);
         pace_sender();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (rsp_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && rsp_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/tsr_pkg.sv
hdl/tsr_stack_ram.sv
hdl/tsr_reg_file.sv
hdl/typed_stack_with_register_table.sv
sim/tb_typed_stack_with_register_table.sv
